@@ rtl/modular_linear_congruence_solver_defines.svh @@
// assertion macros for the congruence solver
`ifndef MODULAR_LINEAR_CONGRUENCE_SOLVER_DEFINES_SVH
`define MODULAR_LINEAR_CONGRUENCE_SOLVER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define MLCS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define MLCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/mlcs_pkg.sv @@
`timescale 1ns / 1ps
package mlcs_pkg;
    localparam int unsigned FW = 31;
    typedef logic [FW-1:0] t_field;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL_START,
        ST_MUL_WAIT,
        ST_CHK_START,
        ST_CHK_WAIT,
        ST_SOL_START,
        ST_SOL_WAIT,
        ST_OUT
    } t_state;

    // divider request and reply
    typedef struct packed {
        logic   start;
        t_field num;
        t_field den;
    } t_div_req;

    typedef struct packed {
        logic   done;
        t_field quo;
        t_field rem;
    } t_div_rsp;

    // modular multiplier request and reply
    typedef struct packed {
        logic   start;
        t_field u;
        t_field v;
        t_field m;
    } t_mul_req;

    typedef struct packed {
        logic   done;
        t_field prod;
    } t_mul_rsp;
endpackage

@@ rtl/mlcs_divider.sv @@
`timescale 1ns / 1ps
module mlcs_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mlcs_pkg::t_div_req i_req,
    output mlcs_pkg::t_div_rsp o_rsp
);
    import mlcs_pkg::*;

    // restoring divider, one quotient bit per cycle
    logic [FW-1:0]   r_quo, n_quo;
    logic [FW:0]     r_rem, n_rem;
    t_field          r_den, n_den;
    logic [4:0]      r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [FW:0]     w_try;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_try  = {r_rem[FW-1:0], r_quo[FW-1]};
        if (i_req.start) begin
            n_quo  = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
            n_cnt  = 5'(FW - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_try >= {1'b0, r_den}) begin
                n_rem = w_try - {1'b0, r_den};
                n_quo = {r_quo[FW-2:0], 1'b1};
            end else begin
                n_rem = w_try;
                n_quo = {r_quo[FW-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem[FW-1:0];
endmodule

@@ rtl/mlcs_mulmod.sv @@
`timescale 1ns / 1ps
module mlcs_mulmod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mlcs_pkg::t_mul_req i_req,
    output mlcs_pkg::t_mul_rsp o_rsp
);
    import mlcs_pkg::*;

    // shift-and-add modular multiply, one multiplier bit per cycle;
    // operands must already be below m
    logic [FW-1:0] r_u, n_u;
    logic [FW-1:0] r_v, n_v;
    logic [FW-1:0] r_m, n_m;
    logic [FW-1:0] r_r, n_r;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [FW:0]   w_sr, w_su;

    always_comb begin
        n_u    = r_u;
        n_v    = r_v;
        n_m    = r_m;
        n_r    = r_r;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sr   = {1'b0, r_r} + {1'b0, r_u};
        w_su   = {1'b0, r_u} + {1'b0, r_u};
        if (i_req.start) begin
            n_u    = i_req.u;
            n_v    = i_req.v;
            n_m    = i_req.m;
            n_r    = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_v == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                if (r_v[0]) begin
                    n_r = (w_sr >= {1'b0, r_m}) ? FW'(w_sr - {1'b0, r_m}) : FW'(w_sr);
                end
                n_u = (w_su >= {1'b0, r_m}) ? FW'(w_su - {1'b0, r_m}) : FW'(w_su);
                n_v = r_v >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_u <= n_u;
        r_v <= n_v;
        r_m <= n_m;
        r_r <= n_r;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_r;
endmodule

@@ rtl/modular_linear_congruence_solver.sv @@
`timescale 1ns / 1ps
// modular linear congruence solver: solves a*y = b (mod m) by extended euclid
// - config: i_cfg_we / i_cfg_data write the 31-bit modulus m (reset value 1);
//   write it only while the block is idle
// - input channel: i_in_valid, o_in_stall, i_coefficient, i_target; a word is
//   accepted when valid is high and stall is low; stall stays high from
//   acceptance until the result word has been taken
// - output channel: o_out_valid, i_out_stall, o_solution, o_no_solution,
//   o_divisor; the result word holds steady while the receiver stalls
// - sequence: each euclid step is one restoring division, with its start state,
//   plus one shift-and-add modular multiply; a quotient at or above m adds a
//   reduction through the divider; then a divisibility check division, a
//   reduction of b/d and a final modular multiply; the multiply stops early
//   once its bezout operand runs out
// - throughput: one word at a time; the shared divider and multiplier set it
// - reset: synchronous active low; clears the sequencer, the handshakes and
//   sets the modulus to 1
module modular_linear_congruence_solver (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  mlcs_pkg::t_field     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mlcs_pkg::t_field     i_coefficient,
    input  mlcs_pkg::t_field     i_target,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mlcs_pkg::t_field     o_solution,
    output logic                 o_no_solution,
    output mlcs_pkg::t_field     o_divisor
);
    import mlcs_pkg::*;
    `include "modular_linear_congruence_solver_defines.svh"

    t_state   r_state, n_state;
    t_field   r_mod;
    t_field   r_b, n_b;
    t_field   r_u, n_u;       // euclid remainder pair
    t_field   r_w, n_w;
    t_field   r_x, n_x;       // bezout coefficients, kept mod m
    t_field   r_xx, n_xx;
    t_field   r_q, n_q;
    t_field   r_sol, n_sol;
    logic     r_none, n_none;
    t_div_req w_dreq;
    t_div_rsp w_drsp;
    t_mul_req w_mreq;
    t_mul_rsp w_mrsp;

    mlcs_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));
    mlcs_mulmod  u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_mreq), .o_rsp(w_mrsp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mod   <= FW'(1);
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mod <= i_cfg_data;
            end
        end
        r_b    <= n_b;
        r_u    <= n_u;
        r_w    <= n_w;
        r_x    <= n_x;
        r_xx   <= n_xx;
        r_q    <= n_q;
        r_sol  <= n_sol;
        r_none <= n_none;
    end

    always_comb begin
        n_state = r_state;
        n_b     = r_b;
        n_u     = r_u;
        n_w     = r_w;
        n_x     = r_x;
        n_xx    = r_xx;
        n_q     = r_q;
        n_sol   = r_sol;
        n_none  = r_none;
        w_dreq  = '{start: 1'b0, num: r_u, den: r_w};
        w_mreq  = '{start: 1'b0, u: r_q, v: r_xx, m: r_mod};
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_u  = i_coefficient;
                    n_w  = r_mod;
                    n_b  = i_target;
                    // x = 1 mod m: zero when m is one or zero
                    n_x  = (r_mod > FW'(1)) ? FW'(1) : '0;
                    n_xx = '0;
                    n_state = ST_DIV_START;
                end
            end
            ST_DIV_START: begin
                if (r_w == '0) begin
                    n_state = ST_CHK_START;
                end else begin
                    w_dreq.start = 1'b1;
                    n_state = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (w_drsp.done) begin
                    n_q = w_drsp.quo;
                    n_u = r_w;
                    n_w = w_drsp.rem;
                    n_state = (r_mod == '0) ? ST_DIV_START : ST_MUL_START;
                end
            end
            ST_MUL_START: begin
                // q reduced mod m; q < m here is not guaranteed on first step
                w_mreq.start = 1'b1;
                w_mreq.u = r_q;
                n_state = ST_MUL_WAIT;
                if (r_q >= r_mod) begin
                    // reuse divider to reduce q
                    w_mreq.start = 1'b0;
                    w_dreq = '{start: 1'b1, num: r_q, den: r_mod};
                    n_state = ST_SOL_WAIT;
                end
            end
            ST_MUL_WAIT: begin
                if (w_mrsp.done) begin
                    n_xx = (r_x >= w_mrsp.prod) ? FW'(r_x - w_mrsp.prod)
                                                : FW'(r_x + (r_mod - w_mrsp.prod));
                    n_x  = r_xx;
                    n_state = ST_DIV_START;
                end
            end
            ST_CHK_START: begin
                if (r_u == '0) begin
                    n_none  = (r_b != '0);
                    n_sol   = '0;
                    n_state = ST_OUT;
                end else begin
                    w_dreq = '{start: 1'b1, num: r_b, den: r_u};
                    n_state = ST_CHK_WAIT;
                end
            end
            ST_CHK_WAIT: begin
                if (w_drsp.done) begin
                    n_none = (w_drsp.rem != '0);
                    n_sol  = '0;
                    if (w_drsp.rem != '0 || r_mod == '0) begin
                        n_state = ST_OUT;
                    end else if (w_drsp.quo >= r_mod) begin
                        // reduce b/d mod m before the multiply
                        n_q = w_drsp.quo;
                        w_dreq = '{start: 1'b1, num: w_drsp.quo, den: r_mod};
                        n_state = ST_SOL_START;
                    end else begin
                        n_q = w_drsp.quo;
                        w_mreq = '{start: 1'b1, u: r_x, v: w_drsp.quo, m: r_mod};
                        n_state = ST_SOL_WAIT;
                    end
                end
            end
            ST_SOL_START: begin
                if (w_drsp.done) begin
                    w_mreq = '{start: 1'b1, u: r_x, v: w_drsp.rem, m: r_mod};
                    n_state = ST_SOL_WAIT;
                end
            end
            ST_SOL_WAIT: begin
                // shared: finishes q reduction during euclid, or final multiply
                if (w_drsp.done) begin
                    n_q = w_drsp.rem;
                    n_state = ST_MUL_START;
                end else if (w_mrsp.done) begin
                    n_sol   = w_mrsp.prod;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = (r_state == ST_OUT);
    assign o_solution    = r_sol;
    assign o_no_solution = r_none;
    assign o_divisor     = r_u;

    `MLCS_ASSERT_IMP(a_flag_zero_sol, o_out_valid && o_no_solution, o_solution == '0)
    `MLCS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_solution) && $stable(o_divisor))
    `MLCS_ASSERT_IMP(a_sol_range, o_out_valid && r_mod != '0, o_solution < r_mod)
endmodule

@@ bench/modular_linear_congruence_solver_tb.sv @@
`timescale 1ns / 1ps
module modular_linear_congruence_solver_tb;
    import mlcs_pkg::*;

    localparam t_field FIELD_MAX = {FW{1'b1}};

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_cfg_we = 1'b0;
    t_field i_cfg_data = '0;
    logic   i_in_valid = 1'b0;
    logic   o_in_stall;
    t_field i_coefficient = '0;
    t_field i_target = '0;
    logic   o_out_valid;
    logic   i_out_stall = 1'b0;
    t_field o_solution;
    logic   o_no_solution;
    t_field o_divisor;

    typedef struct {
        t_field solution;
        logic   no_solution;
        t_field divisor;
    } t_answer;

    t_answer answer_q[$];
    t_field  modulus_copy = 1;
    bit      gaps_on = 1'b1;
    int      fail_count = 0;

    modular_linear_congruence_solver dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_coefficient(i_coefficient), .i_target(i_target),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_solution(o_solution), .o_no_solution(o_no_solution),
        .o_divisor(o_divisor)
    );

    always #5 i_clk = ~i_clk;

    // extended euclid with the bezout coefficient kept as a residue mod m
    function automatic t_answer solve_congruence(t_field a, t_field b, t_field m);
        longint unsigned u, w, q, r, x, xx, t, mq, d;
        t_answer res;
        u = a;
        w = m;
        x = 0;
        xx = 0;
        if (m != 0) x = 1 % m;
        while (w != 0) begin
            q = u / w;
            r = u % w;
            u = w;
            w = r;
            if (m != 0) begin
                t = xx;
                mq = ((q % m) * (xx % m)) % m;
                xx = (x >= mq) ? x - mq : x + (m - mq);
                x = t;
            end
        end
        d = u;
        res.divisor = t_field'(d);
        res.no_solution = (d == 0) ? (b != 0) : ((b % d) != 0);
        res.solution = '0;
        if (!res.no_solution && m != 0 && d != 0)
            res.solution = t_field'(((x % m) * ((b / d) % m)) % m);
        return res;
    endfunction

    function automatic t_field rand_field();
        return t_field'($urandom);
    endfunction

    // receiver backpressure
    always @(posedge i_clk) begin
        i_out_stall <= gaps_on && ($urandom_range(99) < 37);
    end

    // result checker
    always @(posedge i_clk) begin
        t_answer exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (answer_q.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                exp_w = answer_q.pop_front();
                if (o_solution !== exp_w.solution) begin
                    $error("solution exp %0d got %0d", exp_w.solution, o_solution);
                    fail_count++;
                end
                if (o_no_solution !== exp_w.no_solution) begin
                    $error("no_solution exp %0d got %0d", exp_w.no_solution, o_no_solution);
                    fail_count++;
                end
                if (o_divisor !== exp_w.divisor) begin
                    $error("divisor exp %0d got %0d", exp_w.divisor, o_divisor);
                    fail_count++;
                end
            end
        end
    end

    // send one input word, queue its answer at acceptance
    task automatic send_word(t_field a, t_field b);
        int gap;
        gap = 0;
        while (gaps_on && $urandom_range(99) < 37) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_coefficient <= a;
        i_target <= b;
        do @(posedge i_clk); while (o_in_stall);
        answer_q = {answer_q, solve_congruence(a, b, modulus_copy)};
    endtask

    // write the modulus once the block has drained
    task automatic set_modulus(t_field m);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (answer_q.size() != 0) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        modulus_copy = m;
        @(posedge i_clk);
    endtask

    task automatic test_reset_modulus();
        // modulus of one after reset: every solution is zero
        send_word(0, 0);
        send_word(FIELD_MAX, FIELD_MAX);
        send_word(12345, 678);
    endtask

    task automatic test_directed();
        set_modulus(360360);
        send_word(0, 0);
        send_word(0, 720720);
        send_word(0, 5);
        send_word(12, 36);
        send_word(12, 35);
        send_word(FIELD_MAX, FIELD_MAX);
        send_word(360361, 7);
        set_modulus(FIELD_MAX);
        send_word(FIELD_MAX - 1, 1);
        send_word(2, FIELD_MAX);
        send_word(FIELD_MAX, 3);
        // modulus zero: divisor is the coefficient itself
        set_modulus(0);
        send_word(0, 0);
        send_word(0, 1);
        send_word(6, 18);
        send_word(6, 19);
        set_modulus(1);
        send_word(77, 3);
    endtask

    task automatic test_random();
        t_field m, a, b, d;
        longint unsigned y;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: m = rand_field();
                1: m = t_field'($urandom_range(2, 1000));
                2: m = t_field'(1) << $urandom_range(0, FW - 1);
                default: m = t_field'($urandom_range(1, 100)) * t_field'($urandom_range(1, 50000));
            endcase
            set_modulus(m);
            gaps_on = (ph != 3);
            for (int k = 0; k < 46; k++) begin
                case ($urandom_range(3))
                    0: a = rand_field();
                    1: a = t_field'($urandom_range(0, 300));
                    default: a = (m > 1) ? t_field'($urandom % m) : rand_field();
                endcase
                if (m != 0 && $urandom_range(1)) begin
                    // solvable target built from a known answer
                    y = $urandom;
                    b = t_field'(((longint'(a) % m) * (y % m)) % m);
                end else begin
                    b = rand_field();
                end
                send_word(a, b);
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_modulus();
        test_directed();
        test_random();
        i_in_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #200ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
